// ----- rtl/pbkdf2_sha256_key_derive_defines.svh -----
// assertion macros for the pbkdf2 key derivation block
// no dependencies
`ifndef PBKDF2_SHA256_KEY_DERIVE_DEFINES_SVH
`define PBKDF2_SHA256_KEY_DERIVE_DEFINES_SVH
// implication checked at every edge outside reset
`define PBK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PBK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/pbk_pkg.sv -----
// shared types, constants and sha-256 helpers for the pbkdf2 block
// no dependencies
package pbk_pkg;
  localparam int unsigned RoundW = 16;

  typedef enum logic [2:0] {
    BLK_IPAD, BLK_OPAD, BLK_SALT, BLK_MSG, BLK_OUTER
  } blk_sel_t;

  typedef struct packed {
    logic     start;      // begin compression
    blk_sel_t sel;        // which block to feed
    logic     use_iv;     // start from iv, else from base state
    logic     save_ist;   // store result as inner base
    logic     save_ost;   // store result as outer base
    logic     save_inner; // store result as inner digest
    logic     save_mac;   // store result as mac and accumulate
    logic     clr_acc;
    logic     load_key;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] SHA_IV =
    256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;
  localparam logic [255:0] IPAD = {32{8'h36}};
  localparam logic [255:0] OPAD = {32{8'h5c}};
endpackage

// ----- rtl/pbkdf2_sha256_key_derive.sv -----
// pbkdf2-hmac-sha256 top level, one 32-byte block per item
// two sha-256 compressions for the pads, then two per round
// a zero round count skips all compressions and returns an all-zero key
// one item at a time, set by the single shared sha-256 round unit
// next item accepted only after the previous result is taken
// synchronous active-low reset: salt clears, round count returns to 1000
module pbkdf2_sha256_key_derive
  import pbk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_pass_word0,
  input  logic [63:0] in_pass_word1,
  input  logic [63:0] in_pass_word2,
  input  logic [63:0] in_pass_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_key_word0,
  output logic [63:0] out_key_word1,
  output logic [63:0] out_key_word2,
  output logic [63:0] out_key_word3,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [63:0]       salt_r [4];
  logic [RoundW-1:0] rounds_r;
  logic [255:0]      acc;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) salt_r[i] <= '0;
      rounds_r <= RoundW'(1000);
    end else if (wr) begin
      if (cfg_paddr[5] == 1'b0) salt_r[cfg_paddr[4:3]] <= cfg_pwdata;
      else if (cfg_paddr[4:3] == 2'd0) rounds_r <= cfg_pwdata[RoundW-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[5] == 1'b0) cfg_prdata = salt_r[cfg_paddr[4:3]];
    else if (cfg_paddr[4:3] == 2'd0) cfg_prdata = {48'd0, rounds_r};
    else cfg_prdata = '0;
  end

  pbk_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .rounds(rounds_r),
    .sts(sts), .cmd(cmd)
  );

  pbk_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .key_in({in_pass_word0, in_pass_word1, in_pass_word2, in_pass_word3}),
    .salt({salt_r[0], salt_r[1], salt_r[2], salt_r[3]}), .acc(acc)
  );

  assign out_key_word0 = acc[255:192];
  assign out_key_word1 = acc[191:128];
  assign out_key_word2 = acc[127:64];
  assign out_key_word3 = acc[63:0];
endmodule

// ----- rtl/pbk_sha_core.sv -----
// one sha-256 compression, one round per cycle
// depends on pbk_pkg
module pbk_sha_core
  import pbk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] state_in,
  input  logic [511:0] block_in,
  output logic         done,
  output logic [255:0] state_out
);
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [255:0] base_r;
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] s0, s1, t1, t2, e, a, wnew;

  always_comb begin
    a  = v_r[0];
    e  = v_r[4];
    t1 = v_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]}) +
         ((e & v_r[5]) ^ (~e & v_r[6])) + sha_k(rnd_r) + w_r[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) +
         ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]} ^
         (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = wnew;
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block_in[511-32*i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= state_in[255-32*i -: 32];
      base_r <= state_in;
    end else if (busy_r) begin
      w_r <= w_nxt;
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (rnd_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  always_comb begin
    for (int i = 0; i < 8; i++)
      state_out[255-32*i -: 32] = base_r[255-32*i -: 32] + v_r[i];
  end
endmodule

// ----- rtl/pbk_datapath.sv -----
// key, base states, message and accumulator around the sha core
// depends on pbk_pkg and pbk_sha_core
module pbk_datapath
  import pbk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic [255:0] key_in,
  input  logic [255:0] salt,
  output logic [255:0] acc
);
  logic [255:0] key_r, ist_r, ost_r, inner_r, mac_r, acc_r;
  logic [255:0] st_in, st_out;
  logic [511:0] blk;
  logic         done;

  always_comb begin
    unique case (cmd.sel)
      BLK_IPAD:  blk = {key_r ^ IPAD, IPAD};
      BLK_OPAD:  blk = {key_r ^ OPAD, OPAD};
      BLK_SALT:  blk = {salt, 32'h1, 8'h80, 152'd0, 64'd800};
      BLK_MSG:   blk = {mac_r, 8'h80, 184'd0, 64'd768};
      default:   blk = {inner_r, 8'h80, 184'd0, 64'd768};
    endcase
    priority if (cmd.use_iv) st_in = SHA_IV;
    else if (cmd.sel == BLK_OUTER) st_in = ost_r;
    else st_in = ist_r;
  end

  pbk_sha_core u_core (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .state_in(st_in),
    .block_in(blk), .done(done), .state_out(st_out)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= key_in;
    if (cmd.save_ist) ist_r <= st_out;
    if (cmd.save_ost) ost_r <= st_out;
    if (cmd.save_inner) inner_r <= st_out;
    if (cmd.save_mac) mac_r <= st_out;
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.save_mac) acc_r <= acc_r ^ st_out;
  end

  assign sts.done = done;
  assign acc = acc_r;
endmodule

// ----- rtl/pbk_ctrl.sv -----
// sequencer for pads, first and chained hmac passes
// depends on pbk_pkg and the defines header
`include "pbkdf2_sha256_key_derive_defines.svh"
module pbk_ctrl
  import pbk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic [RoundW-1:0] rounds,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_IPAD  = 3'd1;
  localparam logic [2:0] S_OPAD  = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_OUTER = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        st_r, st_nxt;
  logic [RoundW-1:0] n_r, n_nxt;
  logic              first_r, first_nxt;
  logic              go_r, go_nxt;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    st_nxt = st_r;
    n_nxt = n_r;
    first_nxt = first_r;
    go_nxt = 1'b0;
    cmd = '0;
    cmd.sel = BLK_IPAD;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key = 1'b1;
          cmd.clr_acc = 1'b1;
          n_nxt = rounds;
          first_nxt = 1'b1;
          if (rounds == '0) st_nxt = S_OUT;
          else begin
            st_nxt = S_IPAD;
            go_nxt = 1'b1;
          end
        end
      end
      S_IPAD: begin
        cmd.sel = BLK_IPAD;
        cmd.use_iv = 1'b1;
        cmd.start = go_r;
        if (sts.done) begin
          cmd.save_ist = 1'b1;
          st_nxt = S_OPAD;
          go_nxt = 1'b1;
        end
      end
      S_OPAD: begin
        cmd.sel = BLK_OPAD;
        cmd.use_iv = 1'b1;
        cmd.start = go_r;
        if (sts.done) begin
          cmd.save_ost = 1'b1;
          st_nxt = S_INNER;
          go_nxt = 1'b1;
        end
      end
      S_INNER: begin
        cmd.sel = first_r ? BLK_SALT : BLK_MSG;
        cmd.start = go_r;
        if (sts.done) begin
          cmd.save_inner = 1'b1;
          st_nxt = S_OUTER;
          go_nxt = 1'b1;
        end
      end
      S_OUTER: begin
        cmd.sel = BLK_OUTER;
        cmd.start = go_r;
        if (sts.done) begin
          cmd.save_mac = 1'b1;
          first_nxt = 1'b0;
          n_nxt = n_r - 1'b1;
          if (n_r == 1) st_nxt = S_OUT;
          else begin
            st_nxt = S_INNER;
            go_nxt = 1'b1;
          end
        end
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      n_r <= '0;
      first_r <= 1'b0;
      go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      n_r <= n_nxt;
      first_r <= first_nxt;
      go_r <= go_nxt;
    end
  end

  `PBK_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, !in_ready, "busy but ready")
  `PBK_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `PBK_ASSERT_IMP(a_done_busy, clk, rst_n, sts.done, st_r != S_IDLE && st_r != S_OUT,
    "stray done")
endmodule

// ----- dv/pbkdf2_sha256_key_derive_tb.sv -----
// testbench for pbkdf2_sha256_key_derive: directed table then random phases of items
// predicts derived keys with its own sha-256 / hmac model, typed rows carry their key; depends on the rtl only
`timescale 1ns / 1ps
module pbkdf2_sha256_key_derive_tb;

  localparam logic [5:0]   ADDR_SALT0  = 6'd0;
  localparam logic [5:0]   ADDR_ROUNDS = 6'd32;
  localparam logic [5:0]   ADDR_SPARE0 = 6'd40;
  localparam logic [5:0]   ADDR_SPARE1 = 6'd56;
  localparam int           WATCHDOG_LIMIT = 400000;
  localparam int           HOLD_CYCLES = 3000;
  localparam logic [255:0] HASH_IV =
    256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;
  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    bit           write_cfg;
    logic [255:0] salt;
    logic [63:0]  rounds_wr;
    logic [255:0] pass;
    bit           typed;
    logic [255:0] key;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_pass_word0, in_pass_word1, in_pass_word2, in_pass_word3;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_key_word0, out_key_word1, out_key_word2, out_key_word3;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  logic [255:0] salt_reg;
  logic [15:0]  rounds_reg;
  logic [255:0] key_queue[$];
  int           errors, items_sent, keys_checked, cfg_writes, idle_cycles;
  bit           no_idle, hold_armed, cfg_busy;
  stim_row_t    directed[];

  pbkdf2_sha256_key_derive DUT (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_block(input logic [255:0] st, input logic [511:0] blk);
    logic [31:0] w [0:63];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = st;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
            st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + h};
  endfunction

  function automatic logic [255:0] derive_key(input logic [255:0] pass);
    logic [255:0] ist, ost, inner, mac, acc;
    ist = sha_block(HASH_IV, {pass ^ {32{8'h36}}, {32{8'h36}}});
    ost = sha_block(HASH_IV, {pass ^ {32{8'h5c}}, {32{8'h5c}}});
    acc = '0;
    mac = '0;
    for (int n = 0; n < int'(rounds_reg); n++) begin
      if (n == 0) inner = sha_block(ist, {salt_reg, 32'd1, 8'h80, 152'd0, 64'd800});
      else inner = sha_block(ist, {mac, 8'h80, 184'd0, 64'd768});
      mac = sha_block(ost, {inner, 8'h80, 184'd0, 64'd768});
      acc ^= mac;
    end
    return acc;
  endfunction

  task automatic apb_write(input logic [5:0] addr, input logic [63:0] data);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    cfg_writes++;
    if (addr < ADDR_ROUNDS) salt_reg[255 - 64 * addr[4:3] -: 64] = data;
    else if (addr == ADDR_ROUNDS) rounds_reg = data[15:0];
    @(posedge clk);
  endtask

  task automatic apb_check_read(input logic [5:0] addr, input logic [63:0] want);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0; cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== want) begin
      $display("%0t register 0x%0h read: expected %h actual %h", $time, addr, want, cfg_prdata);
      errors++;
    end
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain the block, then program salt, round count and two unused addresses
  task automatic program_block(input logic [255:0] salt, input logic [63:0] rounds_wr);
    in_valid <= 1'b0;
    while (key_queue.size() != 0) @(posedge clk);
    cfg_busy = 1'b1;
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) apb_write(ADDR_SALT0 + 6'(8 * i), salt[255 - 64 * i -: 64]);
    apb_write(ADDR_ROUNDS, rounds_wr);
    apb_write(ADDR_SPARE0, {$urandom, $urandom});
    apb_write(ADDR_SPARE1, {$urandom, $urandom});
    cfg_busy = 1'b0;
  endtask

  function automatic int pick_gap();
    if (no_idle) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
  endfunction

  task automatic send_item(input logic [255:0] pass, input bit typed, input logic [255:0] key);
    int gap;
    bit hs;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_pass_word0, in_pass_word1, in_pass_word2, in_pass_word3} <= pass;
    do begin
      @(negedge clk);
      hs = in_valid && in_ready;
      @(posedge clk);
    end while (!hs);
    key_queue.push_back(typed ? key : derive_key(pass));
    items_sent++;
  endtask

  function automatic logic [255:0] random_words();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32 * i +: 32] = $urandom;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v[255:192] = '1;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; out_ready = 1'b0;
    {in_pass_word0, in_pass_word1, in_pass_word2, in_pass_word3} = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    salt_reg = '0; rounds_reg = 16'd1000;
    errors = 0; items_sent = 0; keys_checked = 0; cfg_writes = 0;
    no_idle = 1'b0; hold_armed = 1'b0; cfg_busy = 1'b0;
    directed = '{
      '{1'b0, '0, 64'd0, '0, 1'b0, '0},
      '{1'b1, '1, 64'd1, '1, 1'b0, '0},
      '{1'b0, '0, 64'd0, '0, 1'b0, '0},
      '{1'b0, '0, 64'd0, {16{16'haaaa}}, 1'b0, '0},
      '{1'b0, '0, 64'd0, {16{16'h5555}}, 1'b0, '0},
      '{1'b1, {16{16'h5555}}, 64'd0, {8{32'h1234_abcd}}, 1'b1, '0},
      '{1'b0, '0, 64'd0, '1, 1'b1, '0},
      '{1'b1, '0, 64'h1_0000, {8{32'h8000_0001}}, 1'b1, '0},
      '{1'b1, {8{32'h0123_4567}}, 64'hffff_ffff_ffff_0003, {4{64'h8000_0000_0000_0001}},
        1'b0, '0},
      '{1'b0, '0, 64'd0, {16{16'h00ff}}, 1'b0, '0},
      '{1'b1, {4{64'hff00_0000_0000_00ff}}, 64'hffff, '0, 1'b1, '0},
      '{1'b0, '0, 64'd0, '1, 1'b1, '0}
    };
    // the row with round count 0xffff is replaced by one that wraps to a zero count; the typed zero rows stay
    directed[10].rounds_wr = 64'h2_0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 4; i++) apb_check_read(ADDR_SALT0 + 6'(8 * i), 64'd0);
    apb_check_read(ADDR_ROUNDS, 64'd1000);

    foreach (directed[r]) begin
      if (directed[r].write_cfg) program_block(directed[r].salt, directed[r].rounds_wr);
      send_item(directed[r].pass, directed[r].typed, directed[r].key);
    end

    hold_armed = 1'b1;
    while (items_sent < 100) begin
      program_block(random_words(), ($urandom_range(0, 5) == 0) ?
                    64'($urandom_range(5, 24)) : 64'($urandom_range(1, 4)));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 12)) send_item(random_words(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (key_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d items sent, %0d derived keys checked, %0d register writes",
             items_sent, keys_checked, cfg_writes);
    $display("salt and round count varied over phases, including zero and wrapped counts");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off while items keep coming
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && out_valid && keys_checked > 14) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0)
          stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
      end
    end
  end

  always @(negedge clk) begin
    logic [255:0] want, got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_key_word0, out_key_word1, out_key_word2, out_key_word3};
      if (key_queue.size() == 0) begin
        $display("%0t unexpected key: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = key_queue.pop_front();
        keys_checked++;
        for (int i = 0; i < 4; i++)
          if (got[255 - 64 * i -: 64] !== want[255 - 64 * i -: 64]) begin
            $display("%0t key_word%0d: expected %h actual %h", $time, i,
                     want[255 - 64 * i -: 64], got[255 - 64 * i -: 64]);
            errors++;
          end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel || cfg_busy)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress, %0d keys outstanding", $time, key_queue.size());
      $display("Verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule

// ----- pbkdf2_sha256_key_derive.f -----
+incdir+rtl
rtl/pbk_pkg.sv
rtl/pbk_sha_core.sv
rtl/pbk_datapath.sv
rtl/pbk_ctrl.sv
rtl/pbkdf2_sha256_key_derive.sv
dv/pbkdf2_sha256_key_derive_tb.sv
